@@ hw/rtl/loted_pkg.sv @@
// Shared types, constants and codes of the line offset table editor.
package loted_pkg;

  localparam int unsigned MAX_LINES = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_LINES);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ID_W      = 32;
  localparam logic [7:0]  NEWLINE   = 8'd10;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_FWD    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_NOMRG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_INS,
    K_DEL,
    K_SPLIT,
    K_JOIN_BK,
    K_JOIN_FW
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_W,
    ST_DECIDE,
    ST_AUX,
    ST_SWP,
    ST_HEAD,
    ST_NEWL,
    ST_REP
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] start_off;
    logic [POS_W-1:0] end_off;
    logic [ID_W-1:0]  ident;
    logic [ID_W-1:0]  version;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    kind_e kind;
    logic  head;
  } alu_ctl_t;

  localparam entry_t RESET_ENTRY = '{start_off: '0, end_off: '0, ident: ID_W'(1),
                                     version: '0, dirty: 1'b0};

endpackage

@@ hw/rtl/loted_entry_alu.sv @@
// Entry update arithmetic for the shift sweep and for the edited line.
module loted_entry_alu (
  input  loted_pkg::alu_ctl_t         ctl_i,
  input  loted_pkg::entry_t           ent_i,
  input  logic [loted_pkg::POS_W-1:0] pos_i,
  input  logic [loted_pkg::POS_W-1:0] aux_end_i,
  input  logic [loted_pkg::ID_W-1:0]  nident_i,
  output loted_pkg::entry_t           wr_o,
  output loted_pkg::entry_t           newl_o
);
  import loted_pkg::*;

  logic up, bump;

  assign up   = (ctl_i.kind == K_INS) || (ctl_i.kind == K_SPLIT);
  assign bump = (ctl_i.kind == K_SPLIT) || (ctl_i.kind == K_JOIN_BK) ||
                (ctl_i.kind == K_JOIN_FW);

  always_comb begin
    wr_o = ent_i;
    if (!ctl_i.head) begin
      wr_o.start_off = up ? ent_i.start_off + POS_W'(1) : ent_i.start_off - POS_W'(1);
      wr_o.end_off   = up ? ent_i.end_off + POS_W'(1) : ent_i.end_off - POS_W'(1);
      wr_o.version   = ent_i.version + (bump ? ID_W'(1) : ID_W'(0));
    end else begin
      wr_o.version = ent_i.version + ID_W'(1);
      case (ctl_i.kind)
        K_INS: wr_o.end_off = ent_i.end_off + POS_W'(1);
        K_DEL: wr_o.end_off = ent_i.end_off - POS_W'(1);
        K_SPLIT: begin
          wr_o.end_off = pos_i + POS_W'(1);
          wr_o.dirty   = 1'b1;
        end
        K_JOIN_BK, K_JOIN_FW: begin
          wr_o.end_off = aux_end_i - POS_W'(1);
          wr_o.dirty   = 1'b1;
        end
        default: wr_o = ent_i;
      endcase
    end
  end

  // The line created by a split starts right after the newline.
  always_comb begin
    newl_o.start_off = pos_i + POS_W'(1);
    newl_o.end_off   = ent_i.end_off + POS_W'(1);
    newl_o.ident     = nident_i;
    newl_o.version   = '0;
    newl_o.dirty     = 1'b1;
  end

endmodule

@@ hw/rtl/line_offset_table_editor.sv @@
// Top level of the line offset table editor: sequencer, line memory and result registers.
//
// The block keeps up to 1024 text lines sorted by start offset in one synchronous memory
// with a registered read. After reset it writes the first line, with busy high. A command
// is taken when start is high and busy is low. It first runs a binary search over the
// lines, at most 11 probes, each a read and then a compare. Editing then sweeps every
// line after the located one through the single read and write port, one line per cycle,
// and finishes with a read-modify-write of the edited line (plus one more write when a
// newline splits a line). A merge first reads the line that is folded in. The lines
// swept are those after the located one, one fewer for a forward merge. The result is
// shown on the output ports for exactly one cycle, marked by done_o, and must be taken
// then, because the block cannot be stalled. busy may already be low during that cycle,
// so the next item can be issued at once; after a split busy stays high in that cycle
// while the new line is written.
module line_offset_table_editor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic [loted_pkg::POS_W-1:0]   pos_i,
  input  logic [7:0]                    char_code_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [loted_pkg::IDX_W-1:0]   line_index_o,
  output logic [loted_pkg::POS_W-1:0]   line_start_o,
  output logic [loted_pkg::POS_W-1:0]   line_end_o,
  output logic [loted_pkg::ID_W-1:0]    line_ident_o,
  output logic [loted_pkg::ID_W-1:0]    line_version_o,
  output logic                          line_dirty_o,
  output logic [loted_pkg::CNT_W-1:0]   line_total_o
);
  import loted_pkg::*;

  // Line memory, one packed entry per line.
  entry_t mem [MAX_LINES];
  entry_t rdata_q;
  logic              re, we;
  logic [IDX_W-1:0]  raddr, waddr;
  entry_t            wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Control state.
  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic              nl_q, nl_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]  mid_q, mid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  tgt_q, tgt_d;
  kind_e             kind_q, kind_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              swp_v_q, swp_v_d;
  logic [IDX_W-1:0]  swp_dst_q, swp_dst_d;
  logic [POS_W-1:0]  aux_end_q, aux_end_d;
  entry_t            newl_q, newl_d;
  status_e           sts_q, sts_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ID_W-1:0]   nident_q, nident_d;

  // Result registers.
  logic              done_q, done_d;
  status_e           o_sts_q, o_sts_d;
  logic [IDX_W-1:0]  o_idx_q, o_idx_d;
  entry_t            o_ent_q, o_ent_d;
  logic [CNT_W-1:0]  o_total_q, o_total_d;

  alu_ctl_t          alu_ctl;
  entry_t            alu_wr, alu_newl;

  loted_entry_alu u_alu (
    .ctl_i     (alu_ctl),
    .ent_i     (rdata_q),
    .pos_i     (pos_q),
    .aux_end_i (aux_end_q),
    .nident_i  (nident_q),
    .wr_o      (alu_wr),
    .newl_o    (alu_newl)
  );

  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_w;
  logic [CNT_W-1:0] idx_c, tail, cnt_m1, lo_m1;
  logic             asc;
  logic [CNT_W-1:0] dst_w;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum[IDX_W:1];
  assign idx_c   = {1'b0, idx_q};
  assign tail    = count_q - idx_c - CNT_W'(1);
  assign cnt_m1  = count_q - CNT_W'(1);
  assign lo_m1   = lo_q - CNT_W'(1);
  assign asc     = (kind_q != K_SPLIT);

  // Destination of the swept line: moved up on a split, down on a merge.
  always_comb begin
    case (kind_q)
      K_SPLIT:              dst_w = ptr_q + CNT_W'(1);
      K_JOIN_BK, K_JOIN_FW: dst_w = ptr_q - CNT_W'(1);
      default:              dst_w = ptr_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    nl_d      = nl_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    kind_d    = kind_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    swp_v_d   = swp_v_q;
    swp_dst_d = swp_dst_q;
    aux_end_d = aux_end_q;
    newl_d    = newl_q;
    sts_d     = sts_q;
    count_d   = count_q;
    nident_d  = nident_q;
    done_d    = 1'b0;
    o_sts_d   = o_sts_q;
    o_idx_d   = o_idx_q;
    o_ent_d   = o_ent_q;
    o_total_d = o_total_q;
    re        = 1'b0;
    raddr     = idx_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = alu_wr;
    alu_ctl.kind = kind_q;
    alu_ctl.head = 1'b0;

    case (state_q)
      ST_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = RESET_ENTRY;
        state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(command_i);
          pos_d   = pos_i;
          nl_d    = (char_code_i == NEWLINE);
          lo_d    = '0;
          hi_d    = count_q;
          state_d = ST_SRCH;
        end
      end

      // Binary search for the last line whose start is at most pos.
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          re      = 1'b1;
          raddr   = mid_w;
          mid_d   = mid_w;
          state_d = ST_SRCH_W;
        end else begin
          idx_d   = (lo_q == '0) ? cnt_m1[IDX_W-1:0] : lo_m1[IDX_W-1:0];
          state_d = ST_DECIDE;
        end
      end

      ST_SRCH_W: begin
        if (pos_q < rdata_q.start_off) begin
          hi_d = {1'b0, mid_q};
        end else begin
          lo_d = {1'b0, mid_q} + CNT_W'(1);
        end
        state_d = ST_SRCH;
      end

      // Pick the edit, or report the located line unchanged.
      ST_DECIDE: begin
        swp_v_d = 1'b0;
        ptr_d   = idx_c + CNT_W'(1);
        cnt_d   = tail;
        tgt_d   = idx_q;
        if (cmd_q == CMD_LOCATE) begin
          sts_d = STS_OK;
        end else if (nl_q && cmd_q == CMD_INSERT && count_q == CNT_W'(MAX_LINES)) begin
          sts_d = STS_FULL;
        end else if (nl_q && cmd_q == CMD_BACK && idx_q == '0) begin
          sts_d = STS_NOMRG;
        end else if (nl_q && cmd_q == CMD_FWD && idx_c + CNT_W'(1) == count_q) begin
          sts_d = STS_NOMRG;
        end else begin
          sts_d = STS_OK;
        end

        if (cmd_q == CMD_LOCATE || sts_d != STS_OK) begin
          re      = 1'b1;
          raddr   = idx_q;
          state_d = ST_REP;
        end else if (!nl_q) begin
          kind_d  = (cmd_q == CMD_INSERT) ? K_INS : K_DEL;
          state_d = ST_SWP;
        end else if (cmd_q == CMD_INSERT) begin
          kind_d  = K_SPLIT;
          ptr_d   = cnt_m1;
          state_d = ST_SWP;
        end else if (cmd_q == CMD_BACK) begin
          // The located line folds into the one before it.
          kind_d  = K_JOIN_BK;
          tgt_d   = idx_q - IDX_W'(1);
          re      = 1'b1;
          raddr   = idx_q;
          state_d = ST_AUX;
        end else begin
          // The next line folds into the located one.
          kind_d  = K_JOIN_FW;
          ptr_d   = idx_c + CNT_W'(2);
          cnt_d   = tail - CNT_W'(1);
          re      = 1'b1;
          raddr   = idx_q + IDX_W'(1);
          state_d = ST_AUX;
        end
      end

      ST_AUX: begin
        aux_end_d = rdata_q.end_off;
        state_d   = ST_SWP;
      end

      // One line read and one line written per cycle.
      ST_SWP: begin
        if (swp_v_q) begin
          we    = 1'b1;
          waddr = swp_dst_q;
        end
        if (cnt_q != '0) begin
          re        = 1'b1;
          raddr     = ptr_q[IDX_W-1:0];
          cnt_d     = cnt_q - CNT_W'(1);
          ptr_d     = asc ? ptr_q + CNT_W'(1) : ptr_q - CNT_W'(1);
          swp_dst_d = dst_w[IDX_W-1:0];
          swp_v_d   = 1'b1;
        end else begin
          swp_v_d = 1'b0;
          re      = 1'b1;
          raddr   = tgt_q;
          state_d = ST_HEAD;
        end
      end

      ST_HEAD: begin
        alu_ctl.head = 1'b1;
        we      = 1'b1;
        waddr   = tgt_q;
        case (kind_q)
          K_SPLIT: begin
            count_d  = count_q + CNT_W'(1);
            nident_d = nident_q + ID_W'(1);
          end
          K_JOIN_BK, K_JOIN_FW: count_d = count_q - CNT_W'(1);
          default: count_d = count_q;
        endcase
        newl_d    = alu_newl;
        done_d    = 1'b1;
        o_sts_d   = STS_OK;
        o_idx_d   = tgt_q;
        o_ent_d   = alu_wr;
        o_total_d = count_d;
        state_d   = (kind_q == K_SPLIT) ? ST_NEWL : ST_IDLE;
      end

      ST_NEWL: begin
        we      = 1'b1;
        waddr   = tgt_q + IDX_W'(1);
        wdata   = newl_q;
        state_d = ST_IDLE;
      end

      ST_REP: begin
        done_d    = 1'b1;
        o_sts_d   = sts_q;
        o_idx_d   = idx_q;
        o_ent_d   = rdata_q;
        o_total_d = count_q;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      count_q  <= CNT_W'(1);
      nident_q <= ID_W'(2);
      swp_v_q  <= 1'b0;
      done_q   <= 1'b0;
      kind_q   <= K_INS;
      cmd_q    <= CMD_LOCATE;
      sts_q    <= STS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      nident_q <= nident_d;
      swp_v_q  <= swp_v_d;
      done_q   <= done_d;
      kind_q   <= kind_d;
      cmd_q    <= cmd_d;
      sts_q    <= sts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nl_q      <= nl_d;
    pos_q     <= pos_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    idx_q     <= idx_d;
    tgt_q     <= tgt_d;
    ptr_q     <= ptr_d;
    cnt_q     <= cnt_d;
    swp_dst_q <= swp_dst_d;
    aux_end_q <= aux_end_d;
    newl_q    <= newl_d;
    o_sts_q   <= o_sts_d;
    o_idx_q   <= o_idx_d;
    o_ent_q   <= o_ent_d;
    o_total_q <= o_total_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = o_sts_q;
  assign line_index_o   = o_idx_q;
  assign line_start_o   = o_ent_q.start_off;
  assign line_end_o     = o_ent_q.end_off;
  assign line_ident_o   = o_ent_q.ident;
  assign line_version_o = o_ent_q.version;
  assign line_dirty_o   = o_ent_q.dirty;
  assign line_total_o   = o_total_q;

  // The line count always stays within the table.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CNT_W'(MAX_LINES))
    else $error("line count out of range");

  // The sweep order never reads a line in the cycle it is being written.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(re && we && raddr == waddr))
    else $error("read and write of the same line in one cycle");

  // Results never come in back to back cycles.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

endmodule
